### src/cjar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cjar_pkg: shared types and constants of the call/jump address restorer
// Holds the register indexes, opcode values, the packet carried from the
// front end to the back end and the configuration bundle.
// ============================================================================
package cjar_pkg;

    // register indexes of the configuration port
    localparam int unsigned CfgIndexWidth = 3;
    localparam logic [CfgIndexWidth-1:0] REG_MARKER     = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_ADD_OFFSET = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_BASE_ADDR  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_MAX_CONV   = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_BUF_LEN    = 3'd4;

    // x86 near call and near jump opcodes
    localparam logic [7:0] OPC_CALL = 8'hE8;
    localparam logic [7:0] OPC_JUMP = 8'hE9;

    // opcodes in the last five bytes of a buffer are never converted
    localparam logic [31:0] TAIL_LEN = 32'd5;

    // default number of packets between front and back end
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // scanner phases
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SCAN  = 6'b000010,
        PH_CHECK = 6'b000100,
        PH_G1    = 6'b001000,
        PH_G2    = 6'b010000,
        PH_G3    = 6'b100000
    } phase_t;

    // one to four output bytes caused by one input transaction
    typedef struct packed {
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      last_idx;  // index of the final byte
        logic            last;      // packet closes the buffer
    } pkt_t;

    // configuration seen by the front end
    typedef struct packed {
        logic [7:0]  marker;
        logic [31:0] add_offset;
        logic [31:0] base_address;
        logic [31:0] max_conversions;
        logic [31:0] scan_limit;    // buffer length minus five
        logic        length_ok;     // buffer length above five
    } cfg_t;

endpackage
`default_nettype wire

### src/cjar_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cjar_front: byte scanner of the call/jump address restorer
// Accepts one byte per cycle while the queue is not full, tracks the buffer
// position and the opcode / marker / target phases, and emits output packets.
// ============================================================================
module cjar_front
    import cjar_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       in_last,
    input  wire logic       q_full,
    output logic            push,
    output pkt_t            push_pkt,
    output logic            buf_idle
);

    phase_t      phase_reg, phase_next;
    logic [31:0] position_reg, position_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] opc_pos_reg, opc_pos_next;
    logic [15:0] held_reg, held_next;
    logic [31:0] k_reg, k_next;

    phase_t      cur_phase;
    logic [31:0] cur_position;
    logic [31:0] cur_remaining;
    logic        accept;
    logic        scan;
    logic        qualifies;
    logic        emit;
    logic [31:0] target;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign buf_idle = (phase_reg == PH_IDLE);

    // a new buffer starts from position zero with a fresh conversion budget
    always_comb
    begin
        if (phase_reg == PH_IDLE)
        begin
            cur_phase     = PH_SCAN;
            cur_position  = '0;
            cur_remaining = cfg.max_conversions;
        end
        else
        begin
            cur_phase     = phase_reg;
            cur_position  = position_reg;
            cur_remaining = remaining_reg;
        end
    end

    // opcode that may carry a converted target
    assign qualifies = (data_byte inside {OPC_CALL, OPC_JUMP}) && cfg.length_ok
                       && (cur_position < cfg.scan_limit) && (cur_remaining != '0);

    // restored target: k_reg already holds add_offset - (opcode pos + 1 + base)
    assign target = {8'h00, held_reg, data_byte} + k_reg;

    // phase sequencing and packet build
    always_comb
    begin
        phase_next            = cur_phase;
        position_next         = cur_position + 32'd1;
        remaining_next        = cur_remaining;
        opc_pos_next          = opc_pos_reg;
        held_next             = held_reg;
        k_next                = k_reg;
        scan                  = 1'b0;
        emit                  = 1'b0;
        push_pkt.bytes        = {4{data_byte}};
        push_pkt.last_idx     = 2'd0;
        push_pkt.last         = in_last;

        case (cur_phase)
            PH_G1:
            begin
                if (in_last)
                begin
                    emit              = 1'b1;
                    push_pkt.bytes[0] = held_reg[7:0];
                    push_pkt.bytes[1] = data_byte;
                    push_pkt.last_idx = 2'd1;
                end
                else
                begin
                    held_next  = {held_reg[7:0], data_byte};
                    k_next     = k_reg - cfg.base_address;
                    phase_next = PH_G2;
                end
            end
            PH_G2:
            begin
                if (in_last)
                begin
                    emit              = 1'b1;
                    push_pkt.bytes[0] = held_reg[15:8];
                    push_pkt.bytes[1] = held_reg[7:0];
                    push_pkt.bytes[2] = data_byte;
                    push_pkt.last_idx = 2'd2;
                end
                else
                begin
                    held_next  = {held_reg[7:0], data_byte};
                    phase_next = PH_G3;
                end
            end
            PH_G3:
            begin
                emit              = 1'b1;
                push_pkt.bytes    = target;
                push_pkt.last_idx = 2'd3;
                remaining_next    = cur_remaining - 32'd1;
                held_next         = '0;
                phase_next        = PH_SCAN;
            end
            PH_CHECK:
            begin
                if ((data_byte == cfg.marker) && !in_last)
                begin
                    held_next  = {8'h00, data_byte};
                    k_next     = cfg.add_offset + ~opc_pos_reg;
                    phase_next = PH_G1;
                end
                else
                begin
                    scan = 1'b1;
                end
            end
            default:
            begin
                scan = 1'b1;
            end
        endcase

        // ordinary byte: pass it and look for an opcode
        if (scan)
        begin
            emit = 1'b1;
            if (!in_last && qualifies)
            begin
                opc_pos_next = cur_position;
                phase_next   = PH_CHECK;
            end
            else
            begin
                phase_next = PH_SCAN;
            end
        end

        // end of buffer
        if (in_last)
        begin
            phase_next    = PH_IDLE;
            position_next = '0;
            held_next     = '0;
        end
    end

    assign push = accept && emit;

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            position_reg  <= '0;
            remaining_reg <= '0;
            opc_pos_reg   <= '0;
            held_reg      <= '0;
            k_reg         <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            remaining_reg <= remaining_next;
            opc_pos_reg   <= opc_pos_next;
            held_reg      <= held_next;
            k_reg         <= k_next;
        end
    end

endmodule
`default_nettype wire

### src/cjar_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cjar_queue: packet queue between scanner and serializer
// Small flip-flop queue of output packets so each side can stall alone.
// ============================================================================
module cjar_queue
    import cjar_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire pkt_t push_pkt,
    output logic      full,
    input  wire logic pop,
    output pkt_t      head,
    output logic      empty
);

    localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

    pkt_t                entry_reg [DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;

    assign full  = (count_reg == FullCnt);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrWidth'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrWidth'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntWidth'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // packet storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule
`default_nettype wire

### src/cjar_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cjar_back: byte serializer of the call/jump address restorer
// Walks the packet at the queue head into the output register one byte per
// cycle while out_ready allows, and releases the packet after its final byte.
// ============================================================================
module cjar_back
    import cjar_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pkt_t       head,
    input  wire logic       empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       final_byte;

    assign load       = !valid_reg || out_ready;
    assign final_byte = (idx_reg == head.last_idx);
    assign pop        = load && !empty && final_byte;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    // byte index and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                idx_next = final_byte ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= head.last && final_byte;
        end
    end

endmodule
`default_nettype wire

### src/call_jump_address_restore.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// call_jump_address_restore: x86 call/jump target restorer
// Scans a decompressed buffer byte by byte and rewrites marked E8/E9 targets
// back to absolute form; all other bytes pass through.
// ============================================================================
// The block takes one byte per cycle while the queue has room and gives one
// byte per cycle while out_ready is high. A marked call or jump target takes
// four input bytes (marker and three target bytes) that produce nothing until
// the last one, which produces the four restored bytes at once; the packet
// queue between the scanner and the serializer (QUEUE_DEPTH packets) absorbs
// these bursts, and the serializer's single output register sets the
// sustained rate of one byte per cycle. in_ready drops only while the queue
// is full. Configuration writes are taken every cycle and must be made
// between buffers.
module call_jump_address_restore
    import cjar_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [31:0]              cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               data_byte,
    input  wire logic                     in_last,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [7:0]                    out_byte,
    output logic                          out_last
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    pkt_t push_pkt;
    pkt_t head_pkt;
    logic buf_idle;

    assign cfg_ready = 1'b1;

    // configuration registers; the length is kept as its scan limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MARKER:     cfg_reg.marker          <= cfg_data[7:0];
                REG_ADD_OFFSET: cfg_reg.add_offset      <= cfg_data;
                REG_BASE_ADDR:  cfg_reg.base_address    <= cfg_data;
                REG_MAX_CONV:   cfg_reg.max_conversions <= cfg_data;
                REG_BUF_LEN:
                begin
                    cfg_reg.scan_limit <= cfg_data - TAIL_LEN;
                    cfg_reg.length_ok  <= (cfg_data > TAIL_LEN);
                end
                default:
                begin
                end
            endcase
        end
    end

    // scanner
    cjar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .push      (q_push),
        .push_pkt  (push_pkt),
        .buf_idle  (buf_idle)
    );

    // packet queue
    cjar_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_pkt (push_pkt),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_pkt),
        .empty    (q_empty)
    );

    // serializer
    cjar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_pkt),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

`ifndef NO_ASSERTIONS
    // queue never written while full
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
        else $error("packet queue overflow");

    // queue never read while empty
    assert property (@(posedge clk) disable iff (!rst_n) q_empty |-> !q_pop)
        else $error("packet queue underflow");

    // the last byte of a buffer always returns the scanner to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> buf_idle)
        else $error("scanner not idle after end of buffer");

    // every accepted last byte leaves a packet behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |-> q_push)
        else $error("end of buffer transaction produced no output");
`endif

endmodule
`default_nettype wire
